// ===== hw/rtl/position_report_framer_crc16_top_macros.svh =====
// Assertion macros for the position report framer checker.
// Used by prfc_checker.sv; expects i_clk and i_rst_n in scope.
`ifndef POSITION_REPORT_FRAMER_CRC16_TOP_MACROS_SVH
`define POSITION_REPORT_FRAMER_CRC16_TOP_MACROS_SVH

// Same-cycle property, disabled while reset is asserted
`define PRFC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define PRFC_ASSERT_NEXT(label, cond, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/prfc_pkg.sv =====
// Shared types, constants and the CRC-16/ARC byte function for the framer.
// No dependencies; imported by every framer module.
package prfc_pkg;

    // Frame layout
    localparam int FRAME_LEN    = 22;
    localparam int BODY_LEN     = 20;   // header through alert byte
    localparam int BODY_IDX_W   = $clog2(BODY_LEN);
    localparam int POS_W        = $clog2(FRAME_LEN);
    localparam int CRC_FIRST    = 2;
    localparam int CRC_DATA_LEN = 18;
    localparam int CRC_SPAN_DEF = 31;

    localparam logic [7:0]  HEADER_BYTE  = 8'h58;   // 'X'
    localparam logic [7:0]  MSG_ID_RESET = 8'd7;
    localparam logic [15:0] CRC_POLY     = 16'hA001;

    // Fixed-point scaling
    localparam int LAT_MULT  = 1000000;
    localparam int ALT_MULT  = 100;
    localparam int LAT_SHIFT = 23;
    localparam int ALT_SHIFT = 16;
    localparam int EPH_MAX   = 255;
    localparam int MULT_W    = $clog2(LAT_MULT + 1);
    localparam int PROD_W    = 32 + MULT_W;

    // Frame queue between front and back
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    typedef logic [BODY_LEN-1:0][7:0] t_body;

    typedef struct packed {
        logic        [7:0]  fleet_id;
        logic        [7:0]  aircraft_id;
        logic signed [31:0] latitude_deg;
        logic signed [31:0] longitude_deg;
        logic signed [31:0] altitude_m;
        logic        [7:0]  vehicle_status;
        logic        [7:0]  gps_fix;
        logic        [7:0]  satellite_count;
        logic        [15:0] horizontal_error;
        logic        [15:0] battery_volts;
        logic        [7:0]  alert_code;
    } t_report;

    typedef enum logic [2:0] {
        FS_IDLE,
        FS_LAT,
        FS_LON,
        FS_ALT,
        FS_PUSH
    } t_front_state;

    // One byte of reflected CRC-16 (poly 0xA001)
    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'd0, b};
        for (int i = 0; i < 8; i++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

// ===== hw/rtl/prfc_fifo.sv =====
// Small frame queue that decouples the front end from the back end.
// Depends on prfc_pkg.
module prfc_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_wr,
    input  prfc_pkg::t_body i_wr_data,
    output logic          o_full,
    input  logic          i_rd,
    output prfc_pkg::t_body o_rd_data,
    output logic          o_empty
);
    import prfc_pkg::*;

    t_body               r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0]  r_wr_ptr;
    logic [Q_PTR_W-1:0]  r_rd_ptr;
    logic [Q_CNT_W-1:0]  r_count;
    logic                w_wr;
    logic                w_rd;

    assign o_full    = (r_count == Q_CNT_W'(Q_DEPTH));
    assign o_empty   = (r_count == '0);
    assign w_wr      = i_wr && !o_full;
    assign w_rd      = i_rd && !o_empty;
    assign o_rd_data = r_mem[r_rd_ptr];

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr_ptr] <= i_wr_data;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_wr) begin
                r_wr_ptr <= (r_wr_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_rd) begin
                r_rd_ptr <= (r_rd_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (w_wr && !w_rd) begin
                r_count <= r_count + 1'b1;
            end else if (w_rd && !w_wr) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// ===== hw/rtl/prfc_front.sv =====
// Front end: takes a report, scales position fields with one shared
// multiplier, and queues the 20-byte frame body. Depends on prfc_pkg.
module prfc_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_wr,
    input  logic [7:0]        i_cfg_data,
    input  logic              i_push,
    output logic              o_full,
    input  prfc_pkg::t_report i_report,
    output logic              o_q_wr,
    output prfc_pkg::t_body   o_q_data,
    input  logic              i_q_full
);
    import prfc_pkg::*;

    t_front_state        r_state;
    t_front_state        n_state;
    t_report             r_rep;
    logic [7:0]          r_message_id;
    logic [PROD_W-1:0]   r_prod;
    logic                r_prod_neg;
    logic [31:0]         r_lat;
    logic [31:0]         r_lon;

    logic [31:0]         w_raw;
    logic [31:0]         w_mag;
    logic [MULT_W-1:0]   w_mult;
    logic [PROD_W-1:0]   w_prod;
    logic [PROD_W-1:0]   w_shifted;
    logic [31:0]         w_scaled;
    logic [19:0]         w_eph_x10;
    logic [19:0]         w_bat_x10;
    logic [7:0]          w_eph;

    // Message id register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_message_id <= MSG_ID_RESET;
        end else if (i_cfg_wr) begin
            r_message_id <= i_cfg_data;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            FS_IDLE: if (i_push) n_state = FS_LAT;
            FS_LAT:  n_state = FS_LON;
            FS_LON:  n_state = FS_ALT;
            FS_ALT:  n_state = FS_PUSH;
            FS_PUSH: if (!i_q_full) n_state = FS_IDLE;
            default: n_state = FS_IDLE;
        endcase
    end

    // State outputs
    always_comb begin
        o_full = 1'b1;
        o_q_wr = 1'b0;
        unique case (r_state)
            FS_IDLE: o_full = 1'b0;
            FS_PUSH: o_q_wr = !i_q_full;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= FS_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Multiplier operand select: magnitude times scale constant
    always_comb begin
        case (r_state)
            FS_LON:  w_raw = r_rep.longitude_deg;
            FS_ALT:  w_raw = r_rep.altitude_m;
            default: w_raw = r_rep.latitude_deg;
        endcase
        w_mult = (r_state == FS_ALT) ? MULT_W'(ALT_MULT) : MULT_W'(LAT_MULT);
        w_mag  = w_raw[31] ? (~w_raw + 32'd1) : w_raw;
        w_prod = w_mag * w_mult;
    end

    // Truncate the previous product toward zero and restore the sign
    always_comb begin
        w_shifted = (r_state == FS_PUSH) ? (r_prod >> ALT_SHIFT) : (r_prod >> LAT_SHIFT);
        w_scaled  = r_prod_neg ? (32'd0 - w_shifted[31:0]) : w_shifted[31:0];
    end

    // Report capture and multiply sequence
    always_ff @(posedge i_clk) begin
        if (r_state == FS_IDLE && i_push) begin
            r_rep <= i_report;
        end
        if (r_state == FS_LAT || r_state == FS_LON || r_state == FS_ALT) begin
            r_prod     <= w_prod;
            r_prod_neg <= w_raw[31];
        end
        if (r_state == FS_LON) begin
            r_lat <= w_scaled;
        end
        if (r_state == FS_ALT) begin
            r_lon <= w_scaled;
        end
    end

    // Tenths: x*10 >> 8, eph clamped to one byte
    always_comb begin
        w_eph_x10 = ({4'd0, r_rep.horizontal_error} << 3) + ({4'd0, r_rep.horizontal_error} << 1);
        w_bat_x10 = ({4'd0, r_rep.battery_volts} << 3) + ({4'd0, r_rep.battery_volts} << 1);
        w_eph     = (w_eph_x10[19:8] > 12'(EPH_MAX)) ? 8'(EPH_MAX) : w_eph_x10[15:8];
    end

    // Frame body, little-endian multi-byte fields
    always_comb begin
        o_q_data      = '0;
        o_q_data[0]   = HEADER_BYTE;
        o_q_data[1]   = r_message_id;
        o_q_data[2]   = r_rep.fleet_id;
        o_q_data[3]   = r_rep.aircraft_id;
        o_q_data[4]   = r_lat[7:0];
        o_q_data[5]   = r_lat[15:8];
        o_q_data[6]   = r_lat[23:16];
        o_q_data[7]   = r_lat[31:24];
        o_q_data[8]   = r_lon[7:0];
        o_q_data[9]   = r_lon[15:8];
        o_q_data[10]  = r_lon[23:16];
        o_q_data[11]  = r_lon[31:24];
        o_q_data[12]  = w_scaled[7:0];
        o_q_data[13]  = w_scaled[15:8];
        o_q_data[14]  = r_rep.vehicle_status;
        o_q_data[15]  = r_rep.gps_fix;
        o_q_data[16]  = r_rep.satellite_count;
        o_q_data[17]  = w_eph;
        o_q_data[18]  = w_bat_x10[15:8];
        o_q_data[19]  = r_rep.alert_code;
    end

endmodule

// ===== hw/rtl/prfc_back.sv =====
// Back end: byte-serial CRC-16/ARC over body bytes 2..19 plus zero padding,
// and the byte emitter with its output register. Depends on prfc_pkg.
module prfc_back #(
    parameter int CRC_SPAN = prfc_pkg::CRC_SPAN_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_q_empty,
    output logic            o_q_rd,
    input  prfc_pkg::t_body i_q_data,
    output logic            o_empty,
    input  logic            i_pop,
    output logic [7:0]      o_frame_byte,
    output logic            o_frame_last
);
    import prfc_pkg::*;

    localparam int CNT_W = $clog2(CRC_SPAN + 1);

    t_body                r_body;
    logic                 r_busy;
    logic [POS_W-1:0]     r_pos;
    logic [CNT_W-1:0]     r_cnt;
    logic [15:0]          r_crc;
    logic                 r_out_valid;
    logic [7:0]           r_out_byte;
    logic                 r_out_last;

    logic                 w_crc_done;
    logic [BODY_IDX_W-1:0] w_crc_idx;
    logic [7:0]           w_crc_in;
    logic                 w_emit;
    logic [7:0]           w_byte;
    logic                 w_last;

    assign o_q_rd       = !r_busy && !i_q_empty;
    assign o_empty      = !r_out_valid;
    assign o_frame_byte = r_out_byte;
    assign o_frame_last = r_out_last;

    // CRC input: body bytes from offset two, then zeros
    always_comb begin
        w_crc_done = (r_cnt == CNT_W'(CRC_SPAN));
        w_crc_idx  = BODY_IDX_W'(CRC_FIRST) + r_cnt[BODY_IDX_W-1:0];
        w_crc_in   = (r_cnt < CNT_W'(CRC_DATA_LEN)) ? r_body[w_crc_idx] : 8'd0;
    end

    // Byte select for the emitter; CRC bytes wait for the CRC to finish
    always_comb begin
        if (r_pos < POS_W'(BODY_LEN)) begin
            w_byte = r_body[r_pos[BODY_IDX_W-1:0]];
        end else if (r_pos == POS_W'(BODY_LEN)) begin
            w_byte = r_crc[7:0];
        end else begin
            w_byte = r_crc[15:8];
        end
        w_last = (r_pos == POS_W'(FRAME_LEN - 1));
        w_emit = r_busy && (!r_out_valid || i_pop)
                 && ((r_pos < POS_W'(BODY_LEN)) || w_crc_done);
    end

    // Frame load, CRC steps and emit position
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_pos  <= '0;
            r_cnt  <= '0;
            r_crc  <= '0;
        end else if (o_q_rd) begin
            r_busy <= 1'b1;
            r_pos  <= '0;
            r_cnt  <= '0;
            r_crc  <= '0;
        end else begin
            if (r_busy && !w_crc_done) begin
                r_crc <= crc_byte(r_crc, w_crc_in);
                r_cnt <= r_cnt + 1'b1;
            end
            if (w_emit) begin
                r_pos <= w_last ? '0 : r_pos + 1'b1;
                if (w_last) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_rd) begin
            r_body <= i_q_data;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_emit) begin
            r_out_valid <= 1'b1;
        end else if (i_pop) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_out_byte <= w_byte;
            r_out_last <= w_last;
        end
    end

endmodule

// ===== hw/rtl/position_report_framer_crc16_top.sv =====
// Position report framer top level: front end, frame queue, back end.
// Depends on prfc_pkg, prfc_front, prfc_fifo and prfc_back.
//
//  channel   | handshake            | payload
//  ----------+----------------------+---------------------------------------
//  report in | push / full          | i_fleet_id .. i_alert_code
//  frame out | empty / pop          | o_frame_byte, o_frame_last
//  config    | cfg_valid/cfg_ready  | i_cfg_data (message id)
//
// The front end steps a report through capture, three shared multiplies and
// a queue write that waits while the queue is full; two bodies can wait
// in the queue behind it. In the back end the CRC unit folds one byte per
// cycle over CRC_SPAN bytes: body bytes 2..19, then zero padding.
// Bytes 0..19 go out while the CRC runs; the two CRC bytes follow it.
// Reset is synchronous and active low; pop held low stalls the back end,
// which in turn fills the queue and raises full.
module position_report_framer_crc16_top #(
    parameter int CRC_SPAN = prfc_pkg::CRC_SPAN_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  i_cfg_data,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_fleet_id,
    input  logic [7:0]  i_aircraft_id,
    input  logic signed [31:0] i_latitude_deg,
    input  logic signed [31:0] i_longitude_deg,
    input  logic signed [31:0] i_altitude_m,
    input  logic [7:0]  i_vehicle_status,
    input  logic [7:0]  i_gps_fix,
    input  logic [7:0]  i_satellite_count,
    input  logic [15:0] i_horizontal_error,
    input  logic [15:0] i_battery_volts,
    input  logic [7:0]  i_alert_code,
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  o_frame_byte,
    output logic        o_frame_last
);
    import prfc_pkg::*;

    t_report w_report;
    t_body   w_wr_body;
    t_body   w_rd_body;
    logic    w_q_wr;
    logic    w_q_full;
    logic    w_q_rd;
    logic    w_q_empty;

    // Register writes are always taken
    assign cfg_ready = 1'b1;

    // Gather the report fields
    always_comb begin
        w_report.fleet_id         = i_fleet_id;
        w_report.aircraft_id      = i_aircraft_id;
        w_report.latitude_deg     = i_latitude_deg;
        w_report.longitude_deg    = i_longitude_deg;
        w_report.altitude_m       = i_altitude_m;
        w_report.vehicle_status   = i_vehicle_status;
        w_report.gps_fix          = i_gps_fix;
        w_report.satellite_count  = i_satellite_count;
        w_report.horizontal_error = i_horizontal_error;
        w_report.battery_volts    = i_battery_volts;
        w_report.alert_code       = i_alert_code;
    end

    prfc_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_wr   (cfg_valid && cfg_ready),
        .i_cfg_data (i_cfg_data),
        .i_push     (push),
        .o_full     (full),
        .i_report   (w_report),
        .o_q_wr     (w_q_wr),
        .o_q_data   (w_wr_body),
        .i_q_full   (w_q_full)
    );

    prfc_fifo u_fifo (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (w_q_wr),
        .i_wr_data (w_wr_body),
        .o_full    (w_q_full),
        .i_rd      (w_q_rd),
        .o_rd_data (w_rd_body),
        .o_empty   (w_q_empty)
    );

    prfc_back #(
        .CRC_SPAN (CRC_SPAN)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_empty    (w_q_empty),
        .o_q_rd       (w_q_rd),
        .i_q_data     (w_rd_body),
        .o_empty      (empty),
        .i_pop        (pop),
        .o_frame_byte (o_frame_byte),
        .o_frame_last (o_frame_last)
    );

endmodule

// ===== hw/rtl/prfc_checker.sv =====
// Port-level checker for the position report framer, bound to the top level.
// Depends on prfc_pkg and position_report_framer_crc16_top_macros.svh.
`include "position_report_framer_crc16_top_macros.svh"

module prfc_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       push,
    input logic       full,
    input logic       empty,
    input logic       pop,
    input logic [7:0] o_frame_byte,
    input logic       o_frame_last
);
    import prfc_pkg::*;

    logic [POS_W-1:0] r_cnt;

    // Byte position within the frame, from popped items
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (pop && !empty) begin
            r_cnt <= o_frame_last ? '0 : r_cnt + 1'b1;
        end
    end

    `PRFC_ASSERT_NEXT(a_out_hold, !empty && !pop, !empty && $stable(o_frame_byte) && $stable(o_frame_last), "stalled item changed")
    `PRFC_ASSERT(a_last_pos, !empty |-> (o_frame_last == (r_cnt == POS_W'(FRAME_LEN - 1))), "last flag off frame end")
    `PRFC_ASSERT(a_header, (!empty && r_cnt == '0) |-> (o_frame_byte == HEADER_BYTE), "frame does not start with header")
    `PRFC_ASSERT_NEXT(a_front_busy, push && !full, full, "front took two reports back to back")

endmodule

bind position_report_framer_crc16_top prfc_checker u_prfc_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .push         (push),
    .full         (full),
    .empty        (empty),
    .pop          (pop),
    .o_frame_byte (o_frame_byte),
    .o_frame_last (o_frame_last)
);
